@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL that carries checks.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock, off during reset.
`define SMSR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("smsr assertion failed");

// Next-cycle implication, checked on the rising clock, off during reset.
`define SMSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("smsr assertion failed");

`endif

@@ rtl/core/smsr_pkg.sv @@
// Shared types, constants and the generator step for the shuffled generator.
// No dependencies; used by the front, queue, back and top level.
package smsr_pkg;

    localparam logic [14:0] LCG_MUL   = 15'd16807;
    localparam logic [31:0] LCG_MOD   = 32'h7FFF_FFFF;
    localparam int          WARMUP_EXTRA = 8;

    // Classified command handed from front to back
    typedef struct packed {
        logic        use_lcg;   // draw from the running state
        logic        seed_pos;  // loaded seed is above zero
        logic [30:0] seed;      // loaded seed when positive
        logic [31:0] start_x;   // warm-up start: negated seed or 1
    } t_cmd;

    // Back-end status seen by the top level
    typedef struct packed {
        logic init_busy;
        logic q_pop;
        logic draw;
    } t_back_status;

    // One step: x * 16807 mod (2^31-1); x may be up to 2^31
    function automatic logic [30:0] f_lcg_step(input logic [31:0] x);
        logic [46:0] prod;
        logic [31:0] fold;
        prod = 47'(x) * 47'(LCG_MUL);
        // 2^31 == 1 mod M, so fold the high part onto the low part
        fold = 32'(prod[46:31]) + {1'b0, prod[30:0]};
        if (fold >= LCG_MOD) begin
            fold = fold - LCG_MOD;
        end
        return fold[30:0];
    endfunction

endpackage

@@ rtl/core/smsr_if.sv @@
// Valid/ready channel interfaces for the request and result items.
// No dependencies.
interface smsr_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] seed_value;

    modport source (output valid, output mode, output seed_value, input ready);
    modport sink   (input valid, input mode, input seed_value, output ready);
endinterface

interface smsr_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] random_value;
    logic [30:0] generator_state;

    modport source (output valid, output random_value, output generator_state, input ready);
    modport sink   (input valid, input random_value, input generator_state, output ready);
endinterface

@@ rtl/core/smsr_front.sv @@
// Front end: accepts request items and classifies them into commands.
// Depends on smsr_pkg and smsr_in_if.
module smsr_front (
    smsr_in_if.sink          i_req,
    input  logic             i_q_full,
    output logic             o_push,
    output smsr_pkg::t_cmd   o_cmd
);

    logic [31:0] neg_seed;

    // Accept whenever the queue has room
    assign i_req.ready = !i_q_full;
    assign o_push      = i_req.valid && !i_q_full;

    // Negated seed; -2^31 becomes 2^31 as an unsigned value
    assign neg_seed = ~i_req.seed_value + 32'd1;

    // Classify the item
    always_comb begin
        o_cmd.use_lcg  = !i_req.mode;
        o_cmd.seed_pos = i_req.mode && (i_req.seed_value > 32'sd0);
        o_cmd.seed     = i_req.seed_value[30:0];
        o_cmd.start_x  = (i_req.mode && i_req.seed_value[31]) ? neg_seed : 32'd1;
    end

endmodule

@@ rtl/core/smsr_queue.sv @@
// Two-entry command queue between the front and back ends.
// Depends on smsr_pkg.
module smsr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  smsr_pkg::t_cmd   i_cmd,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output smsr_pkg::t_cmd   o_cmd
);

    smsr_pkg::t_cmd r_slot [2];
    logic           r_wptr, n_wptr;
    logic           r_rptr, n_rptr;
    logic [1:0]     r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rptr];

    // Pointer and count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = ~r_wptr;
        end
        if (i_pop) begin
            n_rptr = ~r_rptr;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Payload storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

@@ rtl/core/smsr_back.sv @@
// Back end: generator state, warm-up sequencer, shuffle table and result register.
// Depends on smsr_pkg and smsr_out_if.
module smsr_back #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  smsr_pkg::t_cmd         i_cmd,
    output smsr_pkg::t_back_status o_status,
    smsr_out_if.source             o_rsp
);

    localparam int          IDX_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int          CNT_W    = $clog2(TABLE_DEPTH + smsr_pkg::WARMUP_EXTRA);
    localparam logic [31:0] SLOT_DIV = 32'(1 + 2147483646 / TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INIT = 4'b0010,
        S_PREP = 4'b0100,
        S_DRAW = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [31:0]        r_x, n_x;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [30:0]        r_lcg, n_lcg;
    logic [30:0]        r_last, n_last;
    logic [30:0]        r_rd;
    logic               r_out_valid;
    logic [30:0]        r_out_rand;
    logic [30:0]        r_out_state;
    logic [30:0]        mem [TABLE_DEPTH];

    logic [31:0]        mul_in;
    logic [30:0]        step_out;
    logic               out_free;
    logic               q_pop;
    logic               draw;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   slot_last;
    logic [IDX_W-1:0]   slot_rd;
    logic               seed_pos;
    logic [30:0]        sval;
    logic               need_init;
    logic [31:0]        start_x;

    // Slot = v / SLOT_DIV, found by comparing against each slot boundary
    function automatic logic [IDX_W-1:0] f_slot(input logic [30:0] v);
        logic [IDX_W-1:0] s;
        s = '0;
        for (int k = 1; k < TABLE_DEPTH; k++) begin
            if ({1'b0, v} >= 32'(k) * SLOT_DIV) begin
                s = IDX_W'(k);
            end
        end
        return s;
    endfunction

    assign step_out  = smsr_pkg::f_lcg_step(mul_in);
    assign slot_last = f_slot(r_last);
    assign slot_rd   = f_slot(r_rd);
    assign out_free  = !r_out_valid || o_rsp.ready;

    // Decide how the queued command is handled
    assign seed_pos  = i_cmd.use_lcg ? (r_lcg != 31'd0) : i_cmd.seed_pos;
    assign sval      = i_cmd.use_lcg ? r_lcg : i_cmd.seed;
    assign need_init = !seed_pos || (r_last == 31'd0);
    assign start_x   = i_cmd.use_lcg ? 32'd1 : i_cmd.start_x;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_x       = r_x;
        n_cnt     = r_cnt;
        n_lcg     = r_lcg;
        n_last    = r_last;
        q_pop     = 1'b0;
        draw      = 1'b0;
        mul_in    = r_x;
        mem_we    = 1'b0;
        mem_waddr = slot_last;
        rd_en     = 1'b0;
        rd_addr   = slot_rd;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    if (need_init) begin
                        q_pop   = 1'b1;
                        n_x     = start_x;
                        n_cnt   = CNT_W'(TABLE_DEPTH + smsr_pkg::WARMUP_EXTRA - 1);
                        n_state = S_INIT;
                    end else if (out_free) begin
                        q_pop  = 1'b1;
                        draw   = 1'b1;
                        mul_in = {1'b0, sval};
                    end
                end
            end
            S_INIT: begin
                // One warm-up step per cycle; the last steps fill the table
                n_x = {1'b0, step_out};
                if (r_cnt < CNT_W'(TABLE_DEPTH)) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cnt[IDX_W-1:0];
                end
                if (r_cnt == '0) begin
                    n_last  = step_out;
                    n_state = S_PREP;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_PREP: begin
                // Fetch the entry the first draw will hand out
                rd_en   = 1'b1;
                rd_addr = slot_last;
                n_state = S_DRAW;
            end
            S_DRAW: begin
                if (out_free) begin
                    draw    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Draw: swap the new state into the selected slot, prefetch the next one
        if (draw) begin
            n_lcg     = step_out;
            mem_we    = 1'b1;
            mem_waddr = slot_last;
            n_last    = r_rd;
            rd_en     = 1'b1;
            rd_addr   = slot_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_lcg       <= 31'd1;
            r_last      <= 31'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_lcg   <= n_lcg;
            r_last  <= n_last;
            if (draw) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working value and result payload
    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        if (draw) begin
            r_out_rand  <= r_rd;
            r_out_state <= step_out;
        end
    end

    // Shuffle table: one write, one registered read with write bypass
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= step_out;
        end
        if (rd_en) begin
            r_rd <= (mem_we && (mem_waddr == rd_addr)) ? step_out : mem[rd_addr];
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.random_value    = r_out_rand;
    assign o_rsp.generator_state = r_out_state;

    assign o_status.init_busy = (r_state == S_INIT);
    assign o_status.q_pop     = q_pop;
    assign o_status.draw      = draw;

endmodule

@@ rtl/core/shuffled_minimal_standard_rng_top.sv @@
// Top level of the shuffled minimal-standard generator.
// Depends on smsr_pkg, smsr_if, smsr_front, smsr_queue, smsr_back, assert_macros.svh.
//
// Usage:
//   i_req carries one request item per valid/ready handshake: mode 0 draws,
//   mode 1 loads seed_value and then draws. o_rsp returns exactly one result
//   per request: random_value (the shuffled output; divide by 2^31-1 for a
//   uniform deviate) and generator_state (the state after that draw).
//   A request is queued by the front end (two entries) and executed by the
//   back end. A plain draw takes one generator step; the accepted item
//   passes through the queue register and then the result register. Draws
//   sustain one item per cycle while o_rsp is ready and no initialization
//   runs, set by the single multiply-and-fold step unit in the back end.
//   An item that needs initialization (a seed of zero or below, state zero,
//   or after reset) is decoded, runs TABLE_DEPTH+8 warm-up steps at one step
//   per cycle and then does one table read before its draw.
//   Reset sets the state to 1 and the output register to 0, so the first
//   item always initializes. When o_rsp stalls, the result register holds,
//   the queue fills and then i_req.ready drops; nothing is lost.
`include "assert_macros.svh"

module shuffled_minimal_standard_rng_top #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smsr_in_if.sink     i_req,
    smsr_out_if.source  o_rsp
);

    // All-ones state, never reached by a reduced step
    localparam logic [30:0] STATE_ALL_ONES = 31'(smsr_pkg::LCG_MOD);

    logic                   q_full;
    logic                   q_push;
    logic                   q_valid;
    smsr_pkg::t_cmd         front_cmd;
    smsr_pkg::t_cmd         head_cmd;
    smsr_pkg::t_back_status back_st;

    // Classify incoming items
    smsr_front u_front (
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (front_cmd)
    );

    // Decoupling queue
    smsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (back_st.q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // Generator, shuffle table and result register
    smsr_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .o_status  (back_st),
        .o_rsp     (o_rsp)
    );

    // Checks
    `SMSR_ASSERT_IMPL(a_pop_needs_entry, i_clk, i_rst_n, back_st.q_pop, q_valid)
    `SMSR_ASSERT_NEXT(a_draw_shows_result, i_clk, i_rst_n, back_st.draw, o_rsp.valid)
    `SMSR_ASSERT_IMPL(a_no_draw_in_init, i_clk, i_rst_n, back_st.init_busy, !back_st.draw)
    `SMSR_ASSERT_IMPL(a_state_reduced, i_clk, i_rst_n, o_rsp.valid, o_rsp.generator_state != STATE_ALL_ONES)

endmodule
